FILE: rtl/ittf_pkg.sv
// ============================================================================
// ittf_pkg: shared definitions for the integer to text formatter
// Opcodes, character codes, buffer sizes, the digit unit control and status
// structs, and the digit to ASCII glyph function.
// ============================================================================
package ittf_pkg;

    localparam int MAX_FIELD_DEF = 64;

    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int DIGIT_W   = 4;
    localparam int CNT_W     = 7;
    localparam int VALUE_W   = 64;

    // Decimal long division retires this many dividend bits per cycle.
    localparam int DEC_BITS_PER_STEP = 8;
    localparam int DEC_STEPS         = VALUE_W / DEC_BITS_PER_STEP;
    localparam int DEC_PH_W          = $clog2(DEC_STEPS);

    localparam logic [2:0] OP_BIN   = 3'd0;
    localparam logic [2:0] OP_SDEC  = 3'd1;
    localparam logic [2:0] OP_OCT   = 3'd2;
    localparam logic [2:0] OP_UDEC  = 3'd3;
    localparam logic [2:0] OP_HEXL  = 3'd4;
    localparam logic [2:0] OP_HEXU  = 3'd5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        RADIX_2,
        RADIX_8,
        RADIX_10,
        RADIX_16
    } radix_t;

    typedef struct packed {
        logic   load;
        logic   step;
        radix_t radix;
    } digit_ctl_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] digit;
        logic               rest_zero;
    } digit_sts_t;

    function automatic logic [7:0] glyph(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d <= 4'd9) begin
            glyph = CH_ZERO + d8;
        end else if (upper) begin
            glyph = CH_UPPER + d8 - 8'd10;
        end else begin
            glyph = CH_LOWER + d8 - 8'd10;
        end
    endfunction

endpackage

FILE: rtl/ittf_ram.sv
// ============================================================================
// ittf_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module ittf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ittf_digit_unit.sv
// ============================================================================
// ittf_digit_unit: shared digit extraction unit
// Peels off the least significant digit of the held value. Power of two
// radixes shift it out of the low bits; radix ten runs a restoring long
// division that retires DEC_BITS_PER_STEP bits per cycle.
// ============================================================================
module ittf_digit_unit
    import ittf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  digit_ctl_t         ctl,
    input  logic [VALUE_W-1:0] load_mag,
    output digit_sts_t         sts
);

    logic [VALUE_W-1:0]  work_reg, work_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [DEC_PH_W-1:0] phase_reg, phase_next;

    always_comb begin
        logic [DIGIT_W-1:0] r;
        logic [VALUE_W-1:0] w;
        logic [DIGIT_W:0]   t;

        r = rem_reg;
        w = work_reg;
        for (int i = 0; i < DEC_BITS_PER_STEP; i++) begin
            t = {r, w[VALUE_W-1]};
            w = {w[VALUE_W-2:0], 1'b0};
            if (t >= 5'd10) begin
                r    = DIGIT_W'(t - 5'd10);
                w[0] = 1'b1;
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end

        work_next  = work_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        sts.done   = 1'b0;
        sts.digit  = '0;

        case (ctl.radix)
            RADIX_2: begin
                sts.digit = {3'b000, work_reg[0]};
                work_next = work_reg >> 1;
                sts.done  = 1'b1;
            end
            RADIX_8: begin
                sts.digit = {1'b0, work_reg[2:0]};
                work_next = work_reg >> 3;
                sts.done  = 1'b1;
            end
            RADIX_16: begin
                sts.digit = work_reg[3:0];
                work_next = work_reg >> 4;
                sts.done  = 1'b1;
            end
            RADIX_10: begin
                work_next  = w;
                sts.digit  = r;
                sts.done   = (phase_reg == DEC_PH_W'(DEC_STEPS - 1));
                rem_next   = sts.done ? '0 : r;
                phase_next = phase_reg + 1'b1;
            end
            default: begin
                sts.done = 1'b0;
            end
        endcase

        sts.rest_zero = (work_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (ctl.load) begin
            phase_reg <= '0;
        end else if (ctl.step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            work_reg <= load_mag;
            rem_reg  <= '0;
        end else if (ctl.step) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

FILE: rtl/integer_to_text_formatter.sv
// Sequence: accept, then digit conversion in the shared digit unit, then emission
//   of max(width, length) characters through a two-word pipeline, one character
//   per cycle while the output is not stalled by m_ready. A new word is accepted
//   only once ready returns, after the last character enters the pipeline. Reset
//   is synchronous, active low, and clears the sequencer and valid flags; the digit
//   RAM needs no clearing.
// ============================================================================
// integer_to_text_formatter: printf-style integer to ASCII converter
// Takes one integer with a numeric directive and emits the padded text, one
// character per output word, with last marking the end of the field.
// ============================================================================
module integer_to_text_formatter
    import ittf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_opcode,
    input  logic [63:0]  s_value,
    input  logic         s_is_long,
    input  logic [6:0]   s_field_width,
    input  logic         s_left_adjust,
    input  logic         s_zero_pad,

    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_char_out,
    output logic         m_last
);

    // The sequencer: idle, digit conversion, then character emission.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Per-item settings captured when the word is accepted.
    logic             neg_reg;
    logic             upper_reg;
    radix_t           radix_reg;
    logic [CNT_W-1:0] fw_reg;
    logic             ladj_reg;
    logic             zpad_reg;

    // Digit count (digits written to the buffer) and emission index.
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] j_reg, j_next;

    // Middle pipeline stage: the character chosen, waiting on the RAM read.
    logic       b_valid_reg;
    logic       b_digit_reg;
    logic [7:0] b_lit_reg;
    logic       b_upper_reg;
    logic       b_last_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_char_reg;
    logic       m_last_reg;

    // ------------------------------------------------------------------------
    // Input decode. Unknown opcodes are accepted and produce no output.
    // ------------------------------------------------------------------------
    logic               acc;
    logic               op_ok;
    radix_t             radix_in;
    logic               upper_in;
    logic [VALUE_W-1:0] val_ext;
    logic               neg_in;
    logic [VALUE_W-1:0] mag_in;
    logic [CNT_W-1:0]   fw_sat;

    assign s_ready = (state_reg == S_IDLE);
    assign acc     = s_valid && s_ready;

    always_comb begin
        op_ok    = 1'b1;
        upper_in = 1'b0;
        radix_in = RADIX_10;
        case (s_opcode)
            OP_BIN:  radix_in = RADIX_2;
            OP_SDEC: radix_in = RADIX_10;
            OP_OCT:  radix_in = RADIX_8;
            OP_UDEC: radix_in = RADIX_10;
            OP_HEXL: radix_in = RADIX_16;
            OP_HEXU: begin
                radix_in = RADIX_16;
                upper_in = 1'b1;
            end
            default: op_ok = 1'b0;
        endcase
    end

    // A 32-bit value is sign extended only for signed decimal, otherwise
    // zero extended. The most negative value negates to its full magnitude.
    always_comb begin
        if (s_is_long) begin
            val_ext = s_value;
        end else if (s_opcode == OP_SDEC) begin
            val_ext = {{32{s_value[31]}}, s_value[31:0]};
        end else begin
            val_ext = {32'h0000_0000, s_value[31:0]};
        end
        neg_in = (s_opcode == OP_SDEC) && val_ext[VALUE_W-1];
        mag_in = neg_in ? (VALUE_W'(0) - val_ext) : val_ext;
        fw_sat = (s_field_width > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : s_field_width;
    end

    // ------------------------------------------------------------------------
    // Shared digit unit and digit buffer.
    // ------------------------------------------------------------------------
    digit_ctl_t         dctl;
    digit_sts_t         dsts;
    logic               conv_done;
    logic               wr_en;
    logic               adv;
    logic [CNT_W-1:0]   didx;
    logic [DIGIT_W-1:0] rd_data;

    assign dctl.load  = acc && op_ok;
    assign dctl.step  = (state_reg == S_CONV);
    assign dctl.radix = radix_reg;

    ittf_digit_unit u_digit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl),
        .load_mag (mag_in),
        .sts      (dsts)
    );

    assign wr_en     = (state_reg == S_CONV) && dsts.done;
    assign conv_done = wr_en && (dsts.rest_zero || (n_reg == CNT_W'(BUF_DEPTH - 1)));

    ittf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[BUF_AW-1:0]),
        .wr_data (dsts.digit),
        .rd_en   (adv),
        .rd_addr (didx[BUF_AW-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------------
    // Emission: pick the character for field position j. Digits are read
    // from the buffer most significant first.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pad;
    logic [CNT_W-1:0] neg_w;
    logic             sel_digit;
    logic [7:0]       sel_lit;
    logic             is_last;
    logic             issue;

    assign adv   = !m_valid_reg || m_ready;
    assign issue = (state_reg == S_EMIT) && adv;

    always_comb begin
        neg_w     = {{(CNT_W-1){1'b0}}, neg_reg};
        len       = n_reg + neg_w;
        total     = (fw_reg > len) ? fw_reg : len;
        pad       = total - len;
        is_last   = (j_reg == total - 1'b1);
        sel_digit = 1'b0;
        sel_lit   = CH_SPACE;
        didx      = total - 1'b1 - j_reg;
        if (ladj_reg) begin
            // Sign, digits, then trailing spaces.
            didx = len - 1'b1 - j_reg;
            if (neg_reg && (j_reg == '0)) begin
                sel_lit = CH_MINUS;
            end else if (j_reg < len) begin
                sel_digit = 1'b1;
            end else begin
                sel_lit = CH_SPACE;
            end
        end else if (zpad_reg) begin
            // Sign, leading zeros, then digits.
            if (neg_reg && (j_reg == '0)) begin
                sel_lit = CH_MINUS;
            end else if (j_reg < neg_w + pad) begin
                sel_lit = CH_ZERO;
            end else begin
                sel_digit = 1'b1;
            end
        end else begin
            // Leading spaces, sign, then digits.
            if (j_reg < pad) begin
                sel_lit = CH_SPACE;
            end else if (neg_reg && (j_reg == pad)) begin
                sel_lit = CH_MINUS;
            end else begin
                sel_digit = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc && op_ok) begin
                    state_next = S_CONV;
                    n_next     = '0;
                end
            end
            S_CONV: begin
                if (wr_en) begin
                    n_next = n_reg + 1'b1;
                end
                if (conv_done) begin
                    state_next = S_EMIT;
                    j_next     = '0;
                end
            end
            S_EMIT: begin
                if (issue) begin
                    j_next = j_reg + 1'b1;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            n_reg       <= '0;
            j_reg       <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
            if (adv) begin
                b_valid_reg <= issue;
                m_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            neg_reg   <= neg_in;
            upper_reg <= upper_in;
            radix_reg <= radix_in;
            fw_reg    <= fw_sat;
            ladj_reg  <= s_left_adjust;
            zpad_reg  <= s_zero_pad;
        end
        if (adv) begin
            b_digit_reg <= sel_digit;
            b_lit_reg   <= sel_lit;
            b_upper_reg <= upper_reg;
            b_last_reg  <= is_last;
            m_char_reg  <= b_digit_reg ? glyph(rd_data, b_upper_reg) : b_lit_reg;
            m_last_reg  <= b_last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // Every digit read during emission targets a buffer entry written for
    // this word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && sel_digit) |-> (didx < n_reg))
        else $error("digit read beyond the converted digit count");

    // The digit count never runs past the buffer depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (n_reg <= CNT_W'(BUF_DEPTH)))
        else $error("digit count exceeds buffer depth");

    // A word with a known conversion always starts digit conversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && op_ok) |=> (state_reg == S_CONV))
        else $error("accepted word did not start conversion");

    // Issuing the final character of a field returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && is_last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after the last character");

endmodule
